// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the lookahead unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every sampled clock edge outside reset.
`define NWL_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition in one cycle implies a consequence in the next cycle.
`define NWL_ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define NWL_ASSERT(name, clk, rstn, prop, msg)
`define NWL_ASSERT_NEXT(name, clk, rstn, pre, post, msg)
`endif

`endif

// ===== rtl/core/nwl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwl_pkg
// Shared types and constants of the nearest waypoint lookahead unit.
// ----------------------------------------------------------------------------
package nwl_pkg;

  // Fixed field widths of the external interface.
  localparam int LOAD_IDX_W = 10;
  localparam int COORD_IN_W = 32;
  localparam int OUT_IDX_W  = 10;
  localparam int LEN_W      = 32;
  localparam int CNT_REG_W  = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Default sizing.
  localparam int DEF_MAX_WAYPOINTS = 1024;
  localparam int DEF_COORD_BITS    = 32;

  localparam logic [LEN_W-1:0] LOOKAHEAD_RESET = 32'd51200;
  localparam logic [LEN_W-1:0] LEN_MAX         = 32'hFFFF_FFFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WAYPOINT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD_LEN  = 2'd1;

  // Input word command codes.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN_INIT,
    OP_READ_SCAN,
    OP_DIFF_SCAN,
    OP_SQ,
    OP_SCAN_CMP,
    OP_WALK_INIT,
    OP_WALK_LOAD,
    OP_WALK_READ,
    OP_WALK_DIFF,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_WALK_ADD,
    OP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic sq_last;
    logic scan_last;
    logic walk_stop;
    logic sqrt_last;
  } dp_status_t;

endpackage

// ===== rtl/core/nwl_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwl_in_if
// Input channel: load and query words with valid/ready handshake.
// ----------------------------------------------------------------------------
interface nwl_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [9:0]         load_index;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;

  modport source (
    output valid, command, load_index, coord_x, coord_y, coord_z,
    input  ready
  );

  modport sink (
    input  valid, command, load_index, coord_x, coord_y, coord_z,
    output ready
  );
endinterface

// ===== rtl/core/nwl_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwl_out_if
// Output channel: one result word per query with valid/ready handshake.
// ----------------------------------------------------------------------------
interface nwl_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  nearest_index;
  logic [9:0]  end_index;
  logic [31:0] walked_length;
  logic        table_empty;

  modport source (
    output valid, nearest_index, end_index, walked_length, table_empty,
    input  ready
  );

  modport sink (
    input  valid, nearest_index, end_index, walked_length, table_empty,
    output ready
  );
endinterface

// ===== rtl/core/nwl_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwl_dpath
// Waypoint memory, distance squarer, bit-serial square root and walk state.
// ----------------------------------------------------------------------------
module nwl_dpath #(
  parameter int MAX_WAYPOINTS = nwl_pkg::DEF_MAX_WAYPOINTS,
  parameter int COORD_BITS    = nwl_pkg::DEF_COORD_BITS
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [nwl_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [nwl_pkg::CFG_DATA_W-1:0]          cfg_data_i,
  input  logic [nwl_pkg::LOAD_IDX_W-1:0]          load_index_i,
  input  logic signed [nwl_pkg::COORD_IN_W-1:0]   coord_x_i,
  input  logic signed [nwl_pkg::COORD_IN_W-1:0]   coord_y_i,
  input  logic signed [nwl_pkg::COORD_IN_W-1:0]   coord_z_i,
  input  nwl_pkg::dp_cmd_t                        cmd_i,
  output nwl_pkg::dp_status_t                     status_o,
  output logic [nwl_pkg::OUT_IDX_W-1:0]           nearest_index_o,
  output logic [nwl_pkg::OUT_IDX_W-1:0]           end_index_o,
  output logic [nwl_pkg::LEN_W-1:0]               walked_length_o,
  output logic                                    table_empty_o
);
  import nwl_pkg::*;

  localparam int IDX_W  = $clog2(MAX_WAYPOINTS);
  localparam int CNT_W  = $clog2(MAX_WAYPOINTS + 1);
  localparam int CW     = (CNT_W > CNT_REG_W) ? CNT_W : CNT_REG_W;
  localparam int H      = (COORD_BITS + 1) / 2;
  localparam int PP_W   = 2 * H;
  localparam int SQ_W   = 2 * COORD_BITS + 2;
  localparam int RES_W  = SQ_W / 2;
  localparam int REM_W  = RES_W + 3;
  localparam int IT_W   = $clog2(RES_W);
  localparam int SUM_W  = ((RES_W > LEN_W) ? RES_W : LEN_W) + 1;
  localparam int MW     = 3 * COORD_BITS;
  localparam logic [COORD_BITS-1:0] SIGN_BIT = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Map a raw coordinate to offset binary so unsigned order is signed order.
  function automatic logic [COORD_BITS-1:0] bias(input logic [COORD_IN_W-1:0] raw);
    bias = COORD_BITS'(raw) ^ SIGN_BIT;
  endfunction

  function automatic logic [COORD_BITS-1:0] absdiff(input logic [COORD_BITS-1:0] a,
                                                    input logic [COORD_BITS-1:0] b);
    absdiff = (a >= b) ? (a - b) : (b - a);
  endfunction

  // Configuration registers.
  logic [CNT_REG_W-1:0] wp_count_q;
  logic [LEN_W-1:0]     lookahead_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_count_q  <= '0;
      lookahead_q <= LOOKAHEAD_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_WAYPOINT_COUNT) begin
        wp_count_q <= cfg_data_i[CNT_REG_W-1:0];
      end else if (cfg_index_i == CFG_LOOKAHEAD_LEN) begin
        lookahead_q <= cfg_data_i[LEN_W-1:0];
      end
    end
  end

  // Effective count is clamped to the table depth.
  logic [CW-1:0]    cnt_ext;
  logic [CNT_W-1:0] count_eff;
  assign cnt_ext   = CW'(wp_count_q);
  assign count_eff = (cnt_ext > CW'(MAX_WAYPOINTS)) ? CNT_W'(MAX_WAYPOINTS)
                                                   : CNT_W'(cnt_ext);

  // Work registers.
  logic [MW-1:0]         qpt_q, cur_q, rdata_q;
  logic [COORD_BITS-1:0] d0_q, d1_q, d2_q;
  logic [1:0]            axis_q, part_q;
  logic [SQ_W-1:0]       acc_q, best_q, n_q;
  logic [CNT_W-1:0]      scan_i_q;
  logic [IDX_W-1:0]      closest_q, idx_q;
  logic [LEN_W-1:0]      walked_q;
  logic [REM_W-1:0]      rem_q;
  logic [RES_W-1:0]      root_q;
  logic [IT_W-1:0]       iter_q;
  logic                  empty_q;

  // Next walk index with wrap at the effective count.
  logic [CNT_W-1:0] nxt_full;
  logic [IDX_W-1:0] nxt;
  assign nxt_full = CNT_W'(idx_q) + CNT_W'(1);
  assign nxt      = (nxt_full >= count_eff) ? '0 : nxt_full[IDX_W-1:0];

  // Waypoint memory: one write port, one registered read port.
  logic [MW-1:0]    mem [MAX_WAYPOINTS];
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = scan_i_q[IDX_W-1:0];
    unique case (cmd_i.op)
      OP_READ_SCAN: rd_addr = scan_i_q[IDX_W-1:0];
      OP_WALK_INIT: rd_addr = closest_q;
      OP_WALK_READ: rd_addr = nxt;
      default:      rd_en   = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD && int'(load_index_i) < MAX_WAYPOINTS) begin
      mem[IDX_W'(load_index_i)] <= {bias(coord_x_i), bias(coord_y_i), bias(coord_z_i)};
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Squarer: one partial product of half-width halves per cycle.
  logic [COORD_BITS-1:0] d_sel;
  logic [H-1:0]          lo;
  logic [PP_W-1:0]       hi, pp;
  logic [SQ_W-1:0]       pp_sh;

  always_comb begin
    unique case (axis_q)
      2'd0:    d_sel = d0_q;
      2'd1:    d_sel = d1_q;
      default: d_sel = d2_q;
    endcase
    lo = d_sel[H-1:0];
    hi = PP_W'(d_sel[COORD_BITS-1:H]);
    unique case (part_q)
      2'd0: begin
        pp    = PP_W'(lo) * PP_W'(lo);
        pp_sh = SQ_W'(pp);
      end
      2'd1: begin
        pp    = hi * PP_W'(lo);
        pp_sh = SQ_W'(pp) << (H + 1);
      end
      default: begin
        pp    = hi * hi;
        pp_sh = SQ_W'(pp) << (2 * H);
      end
    endcase
  end

  // Square root: one result bit per cycle, restoring.
  logic [REM_W-1:0] rem_sh, trial;
  assign rem_sh = {rem_q[REM_W-3:0], n_q[SQ_W-1 -: 2]};
  assign trial  = REM_W'({root_q, 2'b01});

  // Saturating walk sum.
  logic [SUM_W-1:0] sum;
  assign sum = SUM_W'(walked_q) + SUM_W'(root_q);

  // Sequenced datapath operations.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_SCAN_INIT: begin
        qpt_q    <= {bias(coord_x_i), bias(coord_y_i), bias(coord_z_i)};
        scan_i_q <= '0;
        empty_q  <= (count_eff == '0);
      end
      OP_DIFF_SCAN: begin
        d0_q   <= absdiff(qpt_q[3*COORD_BITS-1 -: COORD_BITS],
                          rdata_q[3*COORD_BITS-1 -: COORD_BITS]);
        d1_q   <= absdiff(qpt_q[2*COORD_BITS-1 -: COORD_BITS],
                          rdata_q[2*COORD_BITS-1 -: COORD_BITS]);
        d2_q   <= absdiff(qpt_q[COORD_BITS-1:0], rdata_q[COORD_BITS-1:0]);
        acc_q  <= '0;
        axis_q <= 2'd0;
        part_q <= 2'd0;
      end
      OP_WALK_DIFF: begin
        d0_q   <= absdiff(cur_q[3*COORD_BITS-1 -: COORD_BITS],
                          rdata_q[3*COORD_BITS-1 -: COORD_BITS]);
        d1_q   <= absdiff(cur_q[2*COORD_BITS-1 -: COORD_BITS],
                          rdata_q[2*COORD_BITS-1 -: COORD_BITS]);
        d2_q   <= absdiff(cur_q[COORD_BITS-1:0], rdata_q[COORD_BITS-1:0]);
        cur_q  <= rdata_q;
        idx_q  <= nxt;
        acc_q  <= '0;
        axis_q <= 2'd0;
        part_q <= 2'd0;
      end
      OP_SQ: begin
        acc_q <= acc_q + pp_sh;
        if (part_q == 2'd2) begin
          part_q <= 2'd0;
          axis_q <= axis_q + 2'd1;
        end else begin
          part_q <= part_q + 2'd1;
        end
      end
      OP_SCAN_CMP: begin
        // The first entry always wins; later ones only on a strict improvement.
        if (scan_i_q == '0 || acc_q < best_q) begin
          best_q    <= acc_q;
          closest_q <= scan_i_q[IDX_W-1:0];
        end
        scan_i_q <= scan_i_q + CNT_W'(1);
      end
      OP_WALK_INIT: begin
        idx_q    <= closest_q;
        walked_q <= '0;
      end
      OP_WALK_LOAD: cur_q <= rdata_q;
      OP_SQRT_INIT: begin
        n_q    <= acc_q;
        rem_q  <= '0;
        root_q <= '0;
        iter_q <= '0;
      end
      OP_SQRT_STEP: begin
        n_q    <= n_q << 2;
        iter_q <= iter_q + IT_W'(1);
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[RES_W-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[RES_W-2:0], 1'b0};
        end
      end
      OP_WALK_ADD: begin
        walked_q <= (sum > SUM_W'(LEN_MAX)) ? LEN_MAX : sum[LEN_W-1:0];
      end
      OP_RESULT: begin
        if (empty_q) begin
          nearest_index_o <= '0;
          end_index_o     <= '0;
          walked_length_o <= '0;
          table_empty_o   <= 1'b1;
        end else begin
          nearest_index_o <= OUT_IDX_W'(closest_q);
          end_index_o     <= OUT_IDX_W'(idx_q);
          walked_length_o <= walked_q;
          table_empty_o   <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Status back to the controller.
  always_comb begin
    status_o.count_zero = (count_eff == '0);
    status_o.sq_last    = (axis_q == 2'd2) && (part_q == 2'd2);
    status_o.scan_last  = ((CNT_W+1)'(scan_i_q) + (CNT_W+1)'(1)) >= (CNT_W+1)'(count_eff);
    status_o.walk_stop  = (walked_q >= lookahead_q) || (nxt == closest_q);
    status_o.sqrt_last  = (iter_q == IT_W'(RES_W - 1));
  end

endmodule

// ===== rtl/core/nwl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwl_ctrl
// Sequencer for load, nearest scan, lookahead walk and result hand-off.
// ----------------------------------------------------------------------------
module nwl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_command_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  input  nwl_pkg::dp_status_t status_i,
  output nwl_pkg::dp_cmd_t    cmd_o
);
  import nwl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SREAD,
    S_SDIFF,
    S_SSQ,
    S_SCMP,
    S_WINIT,
    S_WLOAD,
    S_WCHK,
    S_WDIFF,
    S_WSQ,
    S_SQI,
    S_SQRT,
    S_WADD,
    S_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign in_ready_o  = (state_q == S_IDLE);

  // Operation decode from the current state.
  always_comb begin
    cmd_o.op = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = (in_command_i == CMD_LOAD) ? OP_LOAD : OP_SCAN_INIT;
        end
      end
      S_SREAD: cmd_o.op = OP_READ_SCAN;
      S_SDIFF: cmd_o.op = OP_DIFF_SCAN;
      S_SSQ:   cmd_o.op = OP_SQ;
      S_SCMP:  cmd_o.op = OP_SCAN_CMP;
      S_WINIT: cmd_o.op = OP_WALK_INIT;
      S_WLOAD: cmd_o.op = OP_WALK_LOAD;
      S_WCHK:  cmd_o.op = status_i.walk_stop ? OP_NONE : OP_WALK_READ;
      S_WDIFF: cmd_o.op = OP_WALK_DIFF;
      S_WSQ:   cmd_o.op = OP_SQ;
      S_SQI:   cmd_o.op = OP_SQRT_INIT;
      S_SQRT:  cmd_o.op = OP_SQRT_STEP;
      S_WADD:  cmd_o.op = OP_WALK_ADD;
      S_DONE:  cmd_o.op = out_free ? OP_RESULT : OP_NONE;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  // State register and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_command_i == CMD_QUERY) begin
            state_q <= status_i.count_zero ? S_DONE : S_SREAD;
          end
        end
        S_SREAD: state_q <= S_SDIFF;
        S_SDIFF: state_q <= S_SSQ;
        S_SSQ:   if (status_i.sq_last) state_q <= S_SCMP;
        S_SCMP:  state_q <= status_i.scan_last ? S_WINIT : S_SREAD;
        S_WINIT: state_q <= S_WLOAD;
        S_WLOAD: state_q <= S_WCHK;
        S_WCHK:  state_q <= status_i.walk_stop ? S_DONE : S_WDIFF;
        S_WDIFF: state_q <= S_WSQ;
        S_WSQ:   if (status_i.sq_last) state_q <= S_SQI;
        S_SQI:   state_q <= S_SQRT;
        S_SQRT:  if (status_i.sqrt_last) state_q <= S_WADD;
        S_WADD:  state_q <= S_WCHK;
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/nearest_waypoint_lookahead_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_waypoint_lookahead_unit
// Finds the nearest stored waypoint to a query position and walks the path
// ahead of it until the lookahead length is covered.
// ----------------------------------------------------------------------------
//  Channel  Dir  Word
//  in_i     in   load (index, x, y, z) or query (x, y, z)
//  out_o    out  nearest_index, end_index, walked_length, table_empty
//  cfg      in   waypoint_count (index 0), lookahead_length (index 1)
//
// Loads are taken back to back. A query scans all N stored waypoints, walks
// at most N-1 steps, and opens the input for the next word as its result is
// raised; an empty table skips the scan and walk. Each scanned entry costs a
// memory read and nine partial products on the shared squarer; each walk step
// adds the bit-serial square root. Reset clears only control and configuration;
// the waypoint memory holds garbage until loaded. A stalled result holds in the
// output register; the next word is taken meanwhile, and a following query
// waits before its result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_waypoint_lookahead_unit #(
  parameter int MAX_WAYPOINTS = nwl_pkg::DEF_MAX_WAYPOINTS,
  parameter int COORD_BITS    = nwl_pkg::DEF_COORD_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nwl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [nwl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  nwl_in_if.sink                         in_i,
  nwl_out_if.source                      out_o
);
  import nwl_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Control sequencer.
  nwl_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_i.ready),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // Storage and arithmetic.
  nwl_dpath #(
    .MAX_WAYPOINTS (MAX_WAYPOINTS),
    .COORD_BITS    (COORD_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .load_index_i    (in_i.load_index),
    .coord_x_i       (in_i.coord_x),
    .coord_y_i       (in_i.coord_y),
    .coord_z_i       (in_i.coord_z),
    .cmd_i           (cmd),
    .status_o        (status),
    .nearest_index_o (out_o.nearest_index),
    .end_index_o     (out_o.end_index),
    .walked_length_o (out_o.walked_length),
    .table_empty_o   (out_o.table_empty)
  );

  // An accepted query keeps the input closed for at least the next cycle.
  `NWL_ASSERT_NEXT(a_query_blocks, clk_i, rst_ni, in_i.valid && in_i.ready && in_i.command == CMD_QUERY, !in_i.ready, "input open right after a query")

  // A load never produces a result word.
  `NWL_ASSERT_NEXT(a_load_silent, clk_i, rst_ni, in_i.valid && in_i.ready && in_i.command == CMD_LOAD && !out_o.valid, !out_o.valid, "result after a load")

  // An empty-table result carries all-zero fields.
  `NWL_ASSERT(a_empty_zero, clk_i, rst_ni, out_o.valid && out_o.table_empty |-> out_o.nearest_index == 0 && out_o.end_index == 0 && out_o.walked_length == 0, "empty result not zero")

endmodule

// ===== tb/nearest_waypoint_lookahead_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_waypoint_lookahead_unit_test
// Loads waypoint tables of several sizes, sends position queries under
// varying handshake pressure and checks each result word against a
// behavioral nearest-point search and lookahead walk kept in the bench.
// ----------------------------------------------------------------------------
module nearest_waypoint_lookahead_unit_test;
  import nwl_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int STALL_LIMIT = 400000;

  // Register indexes past the two defined registers.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct {
    logic               command;
    logic [9:0]         load_index;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } waypoint_word_t;

  typedef struct {
    logic [9:0]  nearest_index;
    logic [9:0]  end_index;
    logic [31:0] walked_length;
    logic        table_empty;
  } route_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  nwl_in_if  in_ch ();
  nwl_out_if out_ch ();

  nearest_waypoint_lookahead_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always #1 clk_i = ~clk_i;

  // Bench copy of the table and the registers.
  logic signed [31:0] path_x [TABLE_DEPTH];
  logic signed [31:0] path_y [TABLE_DEPTH];
  logic signed [31:0] path_z [TABLE_DEPTH];
  int unsigned        path_count;
  logic [31:0]        lookahead;

  waypoint_word_t pending_words[$];
  route_word_t    expected_routes[$];
  int             send_idle_pct;
  int             recv_stall_pct;
  logic           hold_sender;
  int             error_count;
  int             quiet_cycles;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  function automatic logic [127:0] dist_sq(input logic signed [31:0] ax, ay, az,
                                           input logic signed [31:0] bx, by, bz);
    longint d [3];
    logic [127:0] acc;
    acc = '0;
    d[0] = longint'(ax) - longint'(bx);
    d[1] = longint'(ay) - longint'(by);
    d[2] = longint'(az) - longint'(bz);
    for (int k = 0; k < 3; k++) begin
      if (d[k] < 0) d[k] = -d[k];
      acc += {64'd0, d[k]} * {64'd0, d[k]};
    end
    return acc;
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= n) r = t;
    end
    return r;
  endfunction

  // Nearest waypoint search followed by the forward walk with wrap-around.
  function automatic route_word_t plan_route(input waypoint_word_t w);
    route_word_t res;
    int unsigned cnt, best_i, idx, nxt;
    logic [127:0] best, d;
    logic [63:0] walked;
    cnt = (path_count > TABLE_DEPTH) ? TABLE_DEPTH : path_count;
    res = '{default: '0};
    if (cnt == 0) begin
      res.table_empty = 1'b1;
      return res;
    end
    best_i = 0;
    best = dist_sq(w.x, w.y, w.z, path_x[0], path_y[0], path_z[0]);
    for (int unsigned i = 1; i < cnt; i++) begin
      d = dist_sq(w.x, w.y, w.z, path_x[i], path_y[i], path_z[i]);
      if (d < best) begin
        best = d;
        best_i = i;
      end
    end
    idx = best_i;
    walked = '0;
    while (walked < {32'd0, lookahead}) begin
      nxt = idx + 1;
      if (nxt >= cnt) nxt = 0;
      if (nxt == best_i) break;
      walked += floor_sqrt(dist_sq(path_x[idx], path_y[idx], path_z[idx],
                                   path_x[nxt], path_y[nxt], path_z[nxt]));
      if (walked > 64'hFFFF_FFFF) walked = 64'hFFFF_FFFF;
      idx = nxt;
    end
    res.nearest_index = best_i[9:0];
    res.end_index = idx[9:0];
    res.walked_length = walked[31:0];
    return res;
  endfunction

  // Word driver: holds a word until taken, then predicts its effect.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        waypoint_word_t w;
        w = pending_words.pop_front();
        if (w.command == CMD_LOAD) begin
          path_x[w.load_index] = w.x;
          path_y[w.load_index] = w.y;
          path_z[w.load_index] = w.z;
        end else begin
          expected_routes.insert(expected_routes.size(), plan_route(w));
        end
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (pending_words.size() > 0 && !hold_sender &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          in_ch.valid      <= 1'b1;
          in_ch.command    <= pending_words[0].command;
          in_ch.load_index <= pending_words[0].load_index;
          in_ch.coord_x    <= pending_words[0].x;
          in_ch.coord_y    <= pending_words[0].y;
          in_ch.coord_z    <= pending_words[0].z;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure and a stall watchdog.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_routes.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          route_word_t e;
          e = expected_routes.pop_front();
          if (out_ch.nearest_index !== e.nearest_index)
            report_mismatch($sformatf("nearest_index %0d, want %0d",
                                      out_ch.nearest_index, e.nearest_index));
          if (out_ch.end_index !== e.end_index)
            report_mismatch($sformatf("end_index %0d, want %0d",
                                      out_ch.end_index, e.end_index));
          if (out_ch.walked_length !== e.walked_length)
            report_mismatch($sformatf("walked_length %0d, want %0d",
                                      out_ch.walked_length, e.walked_length));
          if (out_ch.table_empty !== e.table_empty)
            report_mismatch($sformatf("table_empty %0b, want %0b",
                                      out_ch.table_empty, e.table_empty));
        end
      end
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] pick_coord(input int style);
    case (style)
      0: return $urandom;
      1: return $signed($urandom_range(0, 8000)) - 32'sd4000;
      default: return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
  endfunction

  task automatic queue_load(input int idx, input logic signed [31:0] x, y, z);
    waypoint_word_t w;
    w = '{CMD_LOAD, idx[9:0], x, y, z};
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic queue_query(input logic signed [31:0] x, y, z);
    waypoint_word_t w;
    w = '{CMD_QUERY, 10'($urandom), x, y, z};
    pending_words.insert(pending_words.size(), w);
  endtask

  // Wait until every word is taken and every result word has come back.
  task automatic drain();
    @(negedge clk_i);
    while (pending_words.size() > 0 || expected_routes.size() > 0 || in_ch.valid)
      @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    drain();
    repeat (10) @(negedge clk_i);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    if (idx == CFG_WAYPOINT_COUNT) path_count = val[10:0];
    else if (idx == CFG_LOOKAHEAD_LEN) lookahead = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_mode(input int mode);
    send_idle_pct  = (mode == 1 || mode == 3) ? ((mode == 1) ? 86 : 10) : 0;
    recv_stall_pct = (mode == 2 || mode == 3) ? ((mode == 2) ? 86 : 10) : 0;
  endtask

  // Fill slots below the count, then mix queries with extra loads.
  task automatic run_table(input int cnt, input logic [31:0] la, input int mode,
                           input int n_words);
    int used, style;
    used = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
    style = $urandom_range(0, 2);
    write_reg(CFG_WAYPOINT_COUNT, cnt);
    write_reg(CFG_LOOKAHEAD_LEN, la);
    set_mode(mode);
    for (int i = 0; i < used; i++)
      queue_load(i, pick_coord(style), pick_coord(style), pick_coord(style));
    for (int k = 0; k < n_words; k++) begin
      if (k == n_words / 2) drain();
      if ($urandom_range(0, 3) == 0)
        queue_load(($urandom_range(0, 1) != 0) ? $urandom_range(0, 1023)
                                               : $urandom_range(0, used - 1),
                   pick_coord(style), pick_coord(style), pick_coord(style));
      else
        queue_query(pick_coord(style), pick_coord(style), pick_coord(style));
    end
    drain();
  endtask

  initial begin
    int la_pick;
    logic [31:0] la;
    error_count    = 0;
    hold_sender    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    path_count     = 0;
    lookahead      = LOOKAHEAD_RESET;
    cfg_we_i       = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty table right after reset, extreme positions.
    queue_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    queue_query(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    // Writes to indexes past the two registers must be ignored.
    write_reg(CFG_SPARE_LO, 32'h0000_0005);
    write_reg(CFG_SPARE_HI, 32'hFFFF_FFFF);
    queue_query(32'sd0, 32'sd0, 32'sd0);

    // Single waypoint: the walk cannot move.
    write_reg(CFG_WAYPOINT_COUNT, 1);
    queue_load(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    queue_query(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);

    // Ties go to the lowest index; zero lookahead takes no step.
    write_reg(CFG_WAYPOINT_COUNT, 4);
    write_reg(CFG_LOOKAHEAD_LEN, 0);
    queue_load(0, 32'sd100, 32'sd0, 32'sd0);
    queue_load(1, 32'sd500, 32'sd500, 32'sd7);
    queue_load(2, 32'sd500, 32'sd500, 32'sd7);
    queue_load(3, -32'sd900, 32'sd40, -32'sd3);
    queue_query(32'sd500, 32'sd500, 32'sd7);
    queue_query(32'sd100, 32'sd0, 32'sd0);
    drain();
    // Full-range segments saturate the walked length.
    write_reg(CFG_LOOKAHEAD_LEN, 32'hFFFF_FFFF);
    queue_load(3, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    queue_load(0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    queue_query(32'sd500, 32'sd500, 32'sd7);
    queue_query(32'sh8000_0000, 32'sd0, 32'sh7FFF_FFFF);
    write_reg(CFG_LOOKAHEAD_LEN, LOOKAHEAD_RESET);
    queue_query(-32'sd900, 32'sd40, -32'sd3);

    // Random tables of small sizes under every idling pattern.
    for (int p = 0; p < 10; p++) begin
      la_pick = $urandom_range(0, 4);
      case (la_pick)
        0: la = 32'd0;
        1: la = $urandom_range(1, 20000);
        2: la = LOOKAHEAD_RESET;
        3: la = 32'hFFFF_FFFF;
        default: la = $urandom;
      endcase
      run_table($urandom_range(2, 12), la, p % 4, 20);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
